// ===== rtl/lut3d_trilinear_color_map_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the 3D LUT color map core
// Same-cycle and next-cycle implication checks, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef LUT3D_TRILINEAR_COLOR_MAP_CORE_ASSERT_SVH
`define LUT3D_TRILINEAR_COLOR_MAP_CORE_ASSERT_SVH

// same-cycle implication
`define LUT3D_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// next-cycle implication
`define LUT3D_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

// ===== rtl/lut3d_pkg.sv =====
// ----------------------------------------------------------------------------
// lut3d_pkg
// Shared constants and codes for the 3D LUT trilinear color map core.
// ----------------------------------------------------------------------------
package lut3d_pkg;

    localparam int GRID_POINTS_DEF = 16;
    localparam int IN_DATA_W       = 64;
    localparam int OUT_DATA_W      = 24;
    localparam int ENTRY_W         = 24;
    localparam int SUM_W           = 32;

    localparam logic [7:0]  FULL_SCALE   = 8'd255;
    localparam logic [23:0] WEIGHT_TOTAL = 24'd16581375;   // 255^3

    // floor(x / 255^3) = (x * DIV_MUL) >> DIV_SHIFT, minus at most one
    localparam int DIV_SHIFT = 48;
    localparam logic [24:0] DIV_MUL =
        25'(((64'd1 << DIV_SHIFT) + 64'(WEIGHT_TOTAL) - 64'd1) / 64'(WEIGHT_TOTAL));

    typedef enum logic {
        ACT_WRITE = 1'b0,
        ACT_PIXEL = 1'b1
    } action_t;

    typedef enum logic {
        MODE_NEAREST   = 1'b0,
        MODE_TRILINEAR = 1'b1
    } interp_mode_t;

endpackage

// ===== rtl/lut3d_trilinear_color_map_core.sv =====
// An accepted pixel beat passes through v1_reg..v7_reg and out_valid_reg to m_axis.
// One beat per cycle, writes and pixels alike, while the output is not stalled; the eight
// corners are read together from eight parity banks of the cube.
// A stalled output register stalls the whole pipeline.
// Reset: asynchronous, active low; clears valids, interp_mode back to trilinear.
// Cube contents are not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
// lut3d_trilinear_color_map_core
// Pixel color grading through a parity-banked 3D LUT with trilinear blend.
// ----------------------------------------------------------------------------
module lut3d_trilinear_color_map_core
    import lut3d_pkg::*;
#(
    parameter int GRID_POINTS = GRID_POINTS_DEF   // power of two, 4..16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // entry_index, entry_c0, entry_c1, entry_c2, pix_c0, pix_c1, pix_c2, pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // action
    input  logic                  s_axis_tuser,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // out_c0, out_c1, out_c2
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_data
);

    localparam int GB         = $clog2(GRID_POINTS);
    localparam int HB         = GB - 1;
    localparam int BANK_AW    = 3 * HB;
    localparam int BANK_DEPTH = 1 << BANK_AW;
    localparam int CUBE_AW    = 3 * GB;
    localparam int PW         = 8 + GB;

    // ------------------------------------------------------------------
    // handshake
    logic advance;
    logic accept;
    logic is_pixel;

    assign advance       = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = advance;
    assign accept        = s_axis_tvalid && advance;
    assign is_pixel      = (action_t'(s_axis_tuser) == ACT_PIXEL);
    assign cfg_ready     = 1'b1;

    interp_mode_t interp_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interp_mode_reg <= MODE_TRILINEAR;
        end
        else if (cfg_valid)
        begin
            interp_mode_reg <= interp_mode_t'(cfg_data);
        end
    end

    // ------------------------------------------------------------------
    // write address decode
    logic [11:0]          entry_index;
    logic [ENTRY_W-1:0]   entry_data;
    logic [CUBE_AW+11:0]  idx_ext;
    logic                 wr_in_range;
    logic [GB-1:0]        wi0, wi1, wi2;
    logic [2:0]           wr_bank;
    logic [BANK_AW-1:0]   wr_addr;
    logic                 wr_en;

    assign entry_index = s_axis_tdata[11:0];
    assign entry_data  = s_axis_tdata[35:12];
    assign idx_ext     = {{CUBE_AW{1'b0}}, entry_index};
    assign wr_in_range = (idx_ext[CUBE_AW+11:CUBE_AW] == 12'd0);
    assign wi2         = idx_ext[GB-1:0];
    assign wi1         = idx_ext[2*GB-1:GB];
    assign wi0         = idx_ext[3*GB-1:2*GB];
    assign wr_bank     = {wi0[0], wi1[0], wi2[0]};
    assign wr_addr     = {wi0[GB-1:1], wi1[GB-1:1], wi2[GB-1:1]};
    assign wr_en       = accept && !is_pixel && wr_in_range;

    // ------------------------------------------------------------------
    // axis split: node = c*(G-1)/255, frac = c*(G-1) mod 255
    // axis 0 = pix_c2 (outer), axis 1 = pix_c1, axis 2 = pix_c0 (inner)
    logic [7:0]         pix [3];
    logic [PW-1:0]      sc  [3];
    logic [PW-1:0]      qt  [3];
    logic [GB-1:0]      lo  [3];
    logic [GB-1:0]      lo1 [3];
    logic [7:0]         fr  [3];
    logic [2:0]         lopar;
    logic [BANK_AW-1:0] rd_addr [8];
    logic [HB-1:0]      half [3];

    assign pix[0] = s_axis_tdata[59:52];
    assign pix[1] = s_axis_tdata[51:44];
    assign pix[2] = s_axis_tdata[43:36];

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            sc[a]  = PW'(pix[a]) * PW'(GRID_POINTS - 1);
            qt[a]  = (sc[a] + (sc[a] >> 8) + PW'(1)) >> 8;
            lo[a]  = qt[a][GB-1:0];
            lo1[a] = lo[a] + GB'(1);
            fr[a]  = 8'(sc[a] - ((qt[a] << 8) - qt[a]));
        end
        lopar = {lo[0][0], lo[1][0], lo[2][0]};
        // each bank takes the node of its parity on every axis
        for (int b = 0; b < 8; b++)
        begin
            for (int a = 0; a < 3; a++)
            begin
                if (lo[a][0] == b[2-a])
                    half[a] = lo[a][GB-1:1];
                else
                    half[a] = lo1[a][GB-1:1];
            end
            rd_addr[b] = {half[0], half[1], half[2]};
        end
    end

    // ------------------------------------------------------------------
    // cube banks
    logic [ENTRY_W-1:0] bank_mem [8][BANK_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg [8];

    always_ff @(posedge clk)
    begin
        for (int b = 0; b < 8; b++)
        begin
            if (wr_en && (wr_bank == 3'(b)))
                bank_mem[b][wr_addr] <= entry_data;
            if (accept && is_pixel)
                rd_data_reg[b] <= bank_mem[b][rd_addr[b]];
        end
    end

    // ------------------------------------------------------------------
    // pipeline control
    logic       v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic       out_valid_reg;
    logic [6:0] mode_pipe_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            v7_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg        <= accept && is_pixel;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            v6_reg        <= v5_reg;
            v7_reg        <= v6_reg;
            out_valid_reg <= v7_reg;
        end
    end

    // ------------------------------------------------------------------
    // datapath
    logic [7:0]         fr1_reg [3];
    logic [2:0]         lopar1_reg;
    logic [15:0]        wab2_reg [4];
    logic [7:0]         wc2_reg [2];
    logic [ENTRY_W-1:0] cor2_reg [8];
    logic [23:0]        w3_reg [8];
    logic [ENTRY_W-1:0] cor3_reg [8];
    logic [SUM_W-1:0]   prod4_reg [3][8];
    logic [SUM_W-1:0]   sum5_reg [3][4];
    logic [SUM_W-1:0]   sum6_reg [3];
    logic [SUM_W-1:0]   sum7_reg [3];
    logic [8:0]         qe7_reg [3];
    logic [ENTRY_W-1:0] near_pipe_reg [2:7];
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic [7:0]         wsel [3][2];
    logic [56:0]        mul7 [3];
    logic [32:0]        back [3];
    logic [8:0]         qfix [3];
    logic [OUT_DATA_W-1:0] out_next;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            wsel[a][0] = FULL_SCALE - fr1_reg[a];
            wsel[a][1] = fr1_reg[a];
        end
        for (int c = 0; c < 3; c++)
        begin
            mul7[c] = 57'(sum6_reg[c]) * 57'(DIV_MUL);
            back[c] = 33'(qe7_reg[c]) * 33'(WEIGHT_TOTAL);
            qfix[c] = (back[c] > 33'(sum7_reg[c])) ? qe7_reg[c] - 9'd1 : qe7_reg[c];
        end
        if (interp_mode_t'(mode_pipe_reg[6]) == MODE_TRILINEAR)
            out_next = {qfix[2][7:0], qfix[1][7:0], qfix[0][7:0]};
        else
            out_next = near_pipe_reg[7];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int a = 0; a < 3; a++)
                fr1_reg[a] <= fr[a];
            lopar1_reg    <= lopar;
            mode_pipe_reg <= {mode_pipe_reg[5:0], logic'(interp_mode_reg)};

            // stage 2: two-axis weights and corner select
            for (int j = 0; j < 4; j++)
                wab2_reg[j] <= 16'(wsel[0][j >> 1]) * 16'(wsel[1][j & 1]);
            wc2_reg[0] <= wsel[2][0];
            wc2_reg[1] <= wsel[2][1];
            for (int k = 0; k < 8; k++)
                cor2_reg[k] <= rd_data_reg[lopar1_reg ^ 3'(k)];
            near_pipe_reg[2] <= rd_data_reg[lopar1_reg];

            // stage 3: full corner weights
            for (int k = 0; k < 8; k++)
            begin
                w3_reg[k]   <= 24'(wab2_reg[k >> 1]) * 24'(wc2_reg[k & 1]);
                cor3_reg[k] <= cor2_reg[k];
            end

            // stage 4: weighted corners
            for (int c = 0; c < 3; c++)
                for (int k = 0; k < 8; k++)
                    prod4_reg[c][k] <= SUM_W'(w3_reg[k]) * SUM_W'(cor3_reg[k][8*c +: 8]);

            // stage 5, 6: sum
            for (int c = 0; c < 3; c++)
            begin
                for (int j = 0; j < 4; j++)
                    sum5_reg[c][j] <= prod4_reg[c][2*j] + prod4_reg[c][2*j+1];
                sum6_reg[c] <= (sum5_reg[c][0] + sum5_reg[c][1])
                             + (sum5_reg[c][2] + sum5_reg[c][3]);
            end

            // stage 7: reciprocal estimate of sum / 255^3
            for (int c = 0; c < 3; c++)
            begin
                qe7_reg[c]  <= mul7[c][DIV_SHIFT+8:DIV_SHIFT];
                sum7_reg[c] <= sum6_reg[c];
            end

            for (int s = 3; s <= 7; s++)
                near_pipe_reg[s] <= near_pipe_reg[s-1];

            out_data_reg <= out_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ===== rtl/lut3d_core_chk.sv =====
// ----------------------------------------------------------------------------
// lut3d_core_chk
// Port-level checks for the 3D LUT color map core, bound to the top level.
// ----------------------------------------------------------------------------
`include "lut3d_trilinear_color_map_core_assert.svh"

module lut3d_core_chk
    import lut3d_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready
);

    // a result beat waits until taken, unchanged
    `LUT3D_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `LUT3D_ASSERT_NXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
    // empty output register never blocks the input
    `LUT3D_ASSERT_IMP(a_in_open, !m_axis_tvalid, s_axis_tready)
    // a blocked result freezes the pipeline input
    `LUT3D_ASSERT_IMP(a_in_stall, m_axis_tvalid && !m_axis_tready, !s_axis_tready)

endmodule

bind lut3d_trilinear_color_map_core lut3d_core_chk u_lut3d_core_chk (.*);
